// File: rtl/core/sbe_pkg.sv
package sbe_pkg;

   // angle resolution, full turn is 2**ANGLE_BITS
   localparam int ANGLE_BITS = 16;
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   // quarter sine polynomial coefficients
   localparam logic [14:0] SINE_A = 15'd25736;
   localparam logic [13:0] SINE_B = 14'd10512;
   localparam logic [10:0] SINE_C = 11'd1160;
   localparam logic [14:0] QUARTER = 15'd16384;

   // pipeline stages ahead of the corner holding register
   localparam int PIPE_DEPTH = 8;

   // register indexes
   localparam logic [2:0] CSR_RIGHT_X = 3'd0;
   localparam logic [2:0] CSR_RIGHT_Y = 3'd1;
   localparam logic [2:0] CSR_RIGHT_Z = 3'd2;
   localparam logic [2:0] CSR_UP_X    = 3'd3;
   localparam logic [2:0] CSR_UP_Y    = 3'd4;
   localparam logic [2:0] CSR_UP_Z    = 3'd5;
   localparam logic [2:0] CSR_MODE    = 3'd6;

   localparam logic [2:0] QUAD_CORNERS = 3'd4;
   localparam logic [2:0] TRI_CORNERS  = 3'd6;

   typedef struct packed {
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic [15:0]        spin_angle;
      logic signed [31:0] size_x;
      logic signed [31:0] size_y;
      logic [31:0]        argb;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               tex_u;
      logic               tex_v;
      logic [31:0]        corner_colour;
      logic               last_corner;
   } rsp_type;

   // corner count for the selected primitive
   function automatic logic [2:0] corner_count(input logic tri_mode);
      corner_count = tri_mode ? TRI_CORNERS : QUAD_CORNERS;
   endfunction

   // texture coordinate of a corner, bit 0 u, bit 1 v
   function automatic logic [1:0] corner_uv(input logic tri_mode, input logic [2:0] idx);
      logic [1:0] uv;
      uv = 2'b00;
      if (tri_mode) begin
         unique case (idx)
            3'd0: uv = 2'b00;
            3'd1: uv = 2'b01;
            3'd2: uv = 2'b10;
            3'd3: uv = 2'b10;
            3'd4: uv = 2'b01;
            3'd5: uv = 2'b11;
            default: uv = 2'b00;
         endcase
      end else begin
         unique case (idx)
            3'd0: uv = 2'b00;
            3'd1: uv = 2'b01;
            3'd2: uv = 2'b11;
            3'd3: uv = 2'b10;
            default: uv = 2'b00;
         endcase
      end
      corner_uv = uv;
   endfunction

endpackage

// File: rtl/core/sbe_sine.sv
module sbe_sine (
   input  logic               clock,
   input  logic               enable,
   input  logic [15:0]        phase,
   output logic signed [16:0] sine
);

   logic [14:0] t_in;
   logic [14:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic [3:0]  neg_ff;
   logic [14:0] sq1_ff, sq2_ff;
   logic [13:0] inner_ff;
   logic [14:0] mid_ff;
   logic signed [16:0] sine_ff;
   logic [29:0] sq_prod;
   logic [25:0] c_prod;
   logic [28:0] m_prod;
   logic [29:0] s_prod;

   function automatic logic [14:0] QUARTER_SUB(input logic [13:0] f);
      QUARTER_SUB = sbe_pkg::QUARTER - {1'b0, f};
   endfunction

   // fold the phase into the first quadrant
   assign t_in = phase[14] ? 15'(QUARTER_SUB(phase[13:0])) : {1'b0, phase[13:0]};

   assign sq_prod = 30'(t1_ff) * 30'(t1_ff);
   assign c_prod  = 26'(sq1_ff) * 26'(sbe_pkg::SINE_C);
   assign m_prod  = 29'(sq2_ff) * 29'(inner_ff);
   assign s_prod  = 30'(t4_ff) * 30'(mid_ff);

   // one multiply in each stage after the first
   always_ff @(posedge clock) begin
      if (enable) begin
         t1_ff     <= t_in;
         neg_ff[0] <= phase[15];
         sq1_ff    <= sq_prod[28:14];
         t2_ff     <= t1_ff;
         neg_ff[1] <= neg_ff[0];
         inner_ff  <= sbe_pkg::SINE_B - 14'(c_prod[25:14]);
         sq2_ff    <= sq1_ff;
         t3_ff     <= t2_ff;
         neg_ff[2] <= neg_ff[1];
         mid_ff    <= sbe_pkg::SINE_A - 15'(m_prod[28:14]);
         t4_ff     <= t3_ff;
         neg_ff[3] <= neg_ff[2];
         sine_ff   <= neg_ff[3] ? -$signed({2'b00, s_prod[28:14]})
                                : $signed({2'b00, s_prod[28:14]});
      end
   end

   // t4 and neg_ff[3] travel alongside mid into the last stage
   assign sine = sine_ff;

endmodule

// File: rtl/core/sbe_axis.sv
module sbe_axis (
   input  logic               clock,
   input  logic               enable,
   input  logic               rot,
   input  logic signed [16:0] sn,
   input  logic signed [16:0] cs,
   input  logic signed [15:0] right,
   input  logic signed [15:0] up,
   input  logic signed [31:0] size_x,
   input  logic signed [31:0] size_y,
   output logic signed [35:0] edge_x,
   output logic signed [35:0] edge_y
);

   logic signed [33:0] rs, uc, rc, us, dx_in, dy_in;
   logic signed [31:0] dx_ff, dy_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [63:0] rx, ry;
   logic signed [35:0] ex_ff, ey_ff;

   assign rs = 34'(right) * 34'(sn);
   assign uc = 34'(up) * 34'(cs);
   assign rc = 34'(right) * 34'(cs);
   assign us = 34'(up) * 34'(sn);

   // edge directions in Q4.28
   always_comb begin
      if (rot) begin
         dx_in = rs + uc;
         dy_in = us - rc;
      end else begin
         dx_in = 34'(right) <<< 14;
         dy_in = 34'(up) <<< 14;
      end
   end

   assign rx = px_ff + 64'sd134217728;
   assign ry = py_ff + 64'sd134217728;

   // direction, scaled product, rounded edge
   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff <= 32'(dx_in);
         dy_ff <= 32'(dy_in);
         px_ff <= 64'(dx_ff) * 64'(size_x);
         py_ff <= 64'(dy_ff) * 64'(size_y);
         ex_ff <= 36'(rx >>> 28);
         ey_ff <= 36'(ry >>> 28);
      end
   end

   assign edge_x = ex_ff;
   assign edge_y = ey_ff;

endmodule

// File: rtl/core/sprite_billboard_expander.sv
// Camera-facing sprite expander. Each accepted particle passes through an
// eight-stage pipeline (sine/cosine polynomial, edge direction, scale
// product, rounding) and then yields four quad corners or six triangle
// corners, one per cycle while rsp_stall is low. The pipeline stalls only
// while its last stage holds a particle and the corner holding register is
// busy, so a new particle can be taken while the previous one is still being
// emitted. Each corner leaves through the holding register and the output
// register. Configuration writes are always ready and must be issued
// only while no particle is in flight.
module sprite_billboard_expander (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int D = sbe_pkg::PIPE_DEPTH;

   logic signed [15:0] right_ff [3];
   logic signed [15:0] up_ff [3];
   logic               mode_ff;

   sbe_pkg::req_type stage_ff [D];
   logic [D-1:0]     v_ff;
   logic [D-1:0]     rot_ff;
   logic             adv;
   logic             rot_in;
   logic [31:0]      turn;
   logic [15:0]      phase;
   logic signed [16:0] sn, cs;
   logic signed [35:0] ex [3];
   logic signed [35:0] ey [3];

   logic signed [31:0] hc_ff [3];
   logic signed [35:0] hex_ff [3];
   logic signed [35:0] hey_ff [3];
   logic [31:0]        hargb_ff;
   logic [2:0]         idx_ff;
   logic               hold_v_ff;
   logic               out_load, last, hold_free, hold_load;
   logic [1:0]         uv;
   logic signed [31:0] vert [3];
   sbe_pkg::rsp_type   rsp_ff;
   logic               rsp_v_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff[0] <= 16'sd16384;
         right_ff[1] <= 16'sd0;
         right_ff[2] <= 16'sd0;
         up_ff[0]    <= 16'sd0;
         up_ff[1]    <= 16'sd16384;
         up_ff[2]    <= 16'sd0;
         mode_ff     <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sbe_pkg::CSR_RIGHT_X: right_ff[0] <= csr_wdata;
            sbe_pkg::CSR_RIGHT_Y: right_ff[1] <= csr_wdata;
            sbe_pkg::CSR_RIGHT_Z: right_ff[2] <= csr_wdata;
            sbe_pkg::CSR_UP_X:    up_ff[0]    <= csr_wdata;
            sbe_pkg::CSR_UP_Y:    up_ff[1]    <= csr_wdata;
            sbe_pkg::CSR_UP_Z:    up_ff[2]    <= csr_wdata;
            sbe_pkg::CSR_MODE:    mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // corner emission control
   assign last      = (idx_ff == 3'(sbe_pkg::corner_count(mode_ff) - 3'd1));
   assign out_load  = hold_v_ff && (!rsp_v_ff || !rsp_stall);
   assign hold_free = !hold_v_ff || (out_load && last);
   assign adv       = !v_ff[D-1] || hold_free;
   assign hold_load = adv && v_ff[D-1];
   assign req_stall = !adv;

   // input angle to phase, taken by the first sine stage
   assign turn   = (32'(req_data.spin_angle) & sbe_pkg::ANGLE_MASK)
                   << (32 - sbe_pkg::ANGLE_BITS);
   assign rot_in = (32'(req_data.spin_angle) & sbe_pkg::ANGLE_MASK) != 32'd0;
   assign phase  = turn[31:16];

   // payload delay line
   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff[0] <= req_data;
         rot_ff[0]   <= rot_in;
         for (int i = 1; i < D; i++) begin
            stage_ff[i] <= stage_ff[i-1];
            rot_ff[i]   <= rot_ff[i-1];
         end
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[D-2:0], req_valid};
      end
   end

   sbe_sine u_sin (
      .clock  (clock),
      .enable (adv),
      .phase  (phase),
      .sine   (sn)
   );

   sbe_sine u_cos (
      .clock  (clock),
      .enable (adv),
      .phase  (phase + 16'h4000),
      .sine   (cs)
   );

   // one cell per axis
   for (genvar a = 0; a < 3; a++) begin : g_axis
      sbe_axis u_axis (
         .clock  (clock),
         .enable (adv),
         .rot    (rot_ff[4]),
         .sn     (sn),
         .cs     (cs),
         .right  (right_ff[a]),
         .up     (up_ff[a]),
         .size_x (stage_ff[5].size_x),
         .size_y (stage_ff[5].size_y),
         .edge_x (ex[a]),
         .edge_y (ey[a])
      );
   end

   // corner holding register
   always_ff @(posedge clock) begin
      if (hold_load) begin
         hc_ff[0] <= stage_ff[D-1].centre_x;
         hc_ff[1] <= stage_ff[D-1].centre_y;
         hc_ff[2] <= stage_ff[D-1].centre_z;
         hargb_ff <= stage_ff[D-1].argb;
         for (int i = 0; i < 3; i++) begin
            hex_ff[i] <= ex[i];
            hey_ff[i] <= ey[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         idx_ff    <= 3'd0;
      end else if (hold_load) begin
         hold_v_ff <= 1'b1;
         idx_ff    <= 3'd0;
      end else if (out_load) begin
         hold_v_ff <= !last;
         idx_ff    <= idx_ff + 3'd1;
      end
   end

   // corner sums with saturation
   assign uv = sbe_pkg::corner_uv(mode_ff, idx_ff);
   always_comb begin
      logic signed [37:0] s;
      for (int i = 0; i < 3; i++) begin
         s = 38'(hc_ff[i]) + (uv[0] ? 38'(hex_ff[i]) : -38'(hex_ff[i]))
                           + (uv[1] ? 38'(hey_ff[i]) : -38'(hey_ff[i]));
         if (s > 38'sd2147483647)       vert[i] = 32'sh7FFFFFFF;
         else if (s < -38'sd2147483648) vert[i] = 32'sh80000000;
         else                           vert[i] = 32'(s);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.vert_x        <= vert[0];
         rsp_ff.vert_y        <= vert[1];
         rsp_ff.vert_z        <= vert[2];
         rsp_ff.tex_u         <= uv[0];
         rsp_ff.tex_v         <= uv[1];
         rsp_ff.corner_colour <= hargb_ff;
         rsp_ff.last_corner   <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_load) begin
         rsp_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_v_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // corner index stays inside the primitive
   assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> (idx_ff < sbe_pkg::corner_count(mode_ff)))
      else $error("corner index beyond primitive");

   // first corner of a particle is the 00 corner
   assert property (@(posedge clock) disable iff (reset)
      (out_load && idx_ff == 3'd0) |=> (rsp_valid && !rsp_data.tex_u && !rsp_data.tex_v))
      else $error("first corner not at uv 00");

   // the holding register empties after its last corner unless refilled
   assert property (@(posedge clock) disable iff (reset)
      (out_load && last && !hold_load) |=> !hold_v_ff)
      else $error("holding register not released");

   // last corner flag follows the emission counter
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_data.last_corner == $past(last)))
      else $error("last corner flag mismatch");

endmodule

// File: bench/tb_sprite_billboard_expander.sv
module tb_sprite_billboard_expander;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PARTICLES = 410;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   sbe_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   sbe_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   // camera basis and primitive mode as the bench believes them
   logic signed [15:0] cam_right [3];
   logic signed [15:0] cam_up [3];
   logic tri_mode;

   sbe_pkg::rsp_type corner_queue [$];
   int fail_count;
   int idle_cycles;
   bit quiet_phase;

   sprite_billboard_expander dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // polynomial quarter sine over one quadrant, q1.14
   function automatic longint quarter_sine(input longint t);
      longint t2, inner, mid;
      t2 = (t * t) >>> 14;
      inner = 10512 - ((t2 * 1160) >>> 14);
      mid = 25736 - ((t2 * inner) >>> 14);
      return (t * mid) >>> 14;
   endfunction

   function automatic longint phase_sine(input logic [15:0] p);
      longint f, s;
      f = longint'(p[13:0]);
      s = p[14] ? quarter_sine(16384 - f) : quarter_sine(f);
      return p[15] ? -s : s;
   endfunction

   // round a q36.28 product to the centre format, halves upward
   function automatic longint round_edge(input longint v);
      return (v + (64'sd1 <<< 27)) >>> 28;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // work out the corners of one particle and queue them
   task automatic expand_particle(input sbe_pkg::req_type p);
      longint sn, cs, dx, dy;
      longint ex [3];
      longint ey [3];
      longint ctr [3];
      longint sum;
      logic [1:0] uv;
      int n;
      sbe_pkg::rsp_type c;
      sn = phase_sine(p.spin_angle);
      cs = phase_sine(p.spin_angle + 16'h4000);
      ctr[0] = p.centre_x; ctr[1] = p.centre_y; ctr[2] = p.centre_z;
      for (int i = 0; i < 3; i++) begin
         if (p.spin_angle != 0) begin
            dx = longint'(cam_right[i]) * sn + longint'(cam_up[i]) * cs;
            dy = -(longint'(cam_right[i]) * cs) + longint'(cam_up[i]) * sn;
         end else begin
            dx = longint'(cam_right[i]) * 16384;
            dy = longint'(cam_up[i]) * 16384;
         end
         ex[i] = round_edge(dx * longint'(p.size_x));
         ey[i] = round_edge(dy * longint'(p.size_y));
      end
      n = tri_mode ? 6 : 4;
      for (int k = 0; k < n; k++) begin
         if (tri_mode) uv = (k == 0) ? 2'b00 : (k == 1 || k == 4) ? 2'b01 :
                            (k == 5) ? 2'b11 : 2'b10;
         else uv = (k == 0) ? 2'b00 : (k == 1) ? 2'b01 : (k == 2) ? 2'b11 : 2'b10;
         for (int i = 0; i < 3; i++) begin
            sum = ctr[i] + (uv[0] ? ex[i] : -ex[i]) + (uv[1] ? ey[i] : -ey[i]);
            if (i == 0) c.vert_x = clamp32(sum);
            else if (i == 1) c.vert_y = clamp32(sum);
            else c.vert_z = clamp32(sum);
         end
         c.tex_u = uv[0];
         c.tex_v = uv[1];
         c.corner_colour = p.argb;
         c.last_corner = (k == n - 1);
         corner_queue.push_back(c);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   // result side: random stall bursts, compare each transaction
   initial begin
      sbe_pkg::rsp_type want;
      int burst;
      rsp_stall = 1'b0;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (corner_queue.size() == 0) begin
               report_mismatch("unexpected corner", rsp_data.vert_x, 32'h0);
            end else begin
               want = corner_queue.pop_front();
               if (rsp_data.vert_x !== want.vert_x)
                  report_mismatch("vert_x", rsp_data.vert_x, want.vert_x);
               if (rsp_data.vert_y !== want.vert_y)
                  report_mismatch("vert_y", rsp_data.vert_y, want.vert_y);
               if (rsp_data.vert_z !== want.vert_z)
                  report_mismatch("vert_z", rsp_data.vert_z, want.vert_z);
               if (rsp_data.tex_u !== want.tex_u)
                  report_mismatch("tex_u", rsp_data.tex_u, want.tex_u);
               if (rsp_data.tex_v !== want.tex_v)
                  report_mismatch("tex_v", rsp_data.tex_v, want.tex_v);
               if (rsp_data.corner_colour !== want.corner_colour)
                  report_mismatch("corner_colour", rsp_data.corner_colour,
                                  want.corner_colour);
               if (rsp_data.last_corner !== want.last_corner)
                  report_mismatch("last_corner", rsp_data.last_corner,
                                  want.last_corner);
            end
         end
         @(negedge clock);
         if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sprite_billboard_expander regression: fail");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == sbe_pkg::CSR_MODE) tri_mode = val[0];
      else if (idx < sbe_pkg::CSR_UP_X) cam_right[idx] = val;
      else cam_up[idx - sbe_pkg::CSR_UP_X] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain everything, then give the pipeline time to empty
   task automatic wait_drained();
      while (corner_queue.size() != 0) @(posedge clock);
      repeat (sbe_pkg::PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic send_particle(input sbe_pkg::req_type p);
      int gap;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      expand_particle(p);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   function automatic sbe_pkg::req_type rand_particle();
      sbe_pkg::req_type p;
      p.centre_x = rand_coord();
      p.centre_y = rand_coord();
      p.centre_z = rand_coord();
      p.spin_angle = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom());
      p.size_x = rand_coord();
      p.size_y = rand_coord();
      p.argb = $urandom();
      return p;
   endfunction

   // directed rows: centre xyz, angle, size xy, colour
   typedef struct {
      logic [31:0] cx, cy, cz;
      logic [15:0] ang;
      logic [31:0] sx, sy, col;
   } particle_row;

   particle_row directed [] = '{
      '{32'h0, 32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 32'h0},
      '{32'h00010000, 32'h00020000, 32'h00030000, 16'h0000, 32'h00010000,
        32'h00010000, 32'hffffffff},
      '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0000, 32'h7fffffff,
        32'h7fffffff, 32'h12345678},
      '{32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 32'h80000000,
        32'h80000000, 32'h87654321},
      '{32'h0, 32'h0, 32'h0, 16'h4000, 32'h00010000, 32'h00010000, 32'haa55aa55},
      '{32'h0, 32'h0, 32'h0, 16'h8000, 32'h00010000, 32'h00010000, 32'h55aa55aa},
      '{32'h0, 32'h0, 32'h0, 16'hc000, 32'h00010000, 32'h00010000, 32'h1},
      '{32'h0, 32'h0, 32'h0, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h2},
      '{32'h0, 32'h0, 32'h0, 16'h0001, 32'hffffffff, 32'h00000001, 32'h3},
      '{32'h7fff0000, 32'h80010000, 32'h0, 16'h2000, 32'h40000000,
        32'hc0000000, 32'h4},
      '{32'hffffffff, 32'h1, 32'h7ffffffe, 16'h3fff, 32'h00008000,
        32'h00018000, 32'h5}
   };

   initial begin
      sbe_pkg::req_type p;
      sbe_pkg::rsp_type first;
      fail_count = 0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = sbe_pkg::CSR_RIGHT_X;
      csr_wdata = '0;
      cam_right = '{16'sd16384, 16'sd0, 16'sd0};
      cam_up = '{16'sd0, 16'sd16384, 16'sd0};
      tri_mode = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset basis: first corner of a unit sprite at the origin is (-1,-1,0)
      p = '{32'sh0, 32'sh0, 32'sh0, 16'h0, 32'sh00010000, 32'sh00010000, 32'hcafef00d};
      send_particle(p);
      first = corner_queue[0];
      if (first.vert_x !== 32'hffff0000 || first.vert_y !== 32'hffff0000 ||
          first.vert_z !== 32'h0) begin
         $display("reset basis corner wrong in predictor");
         fail_count++;
      end

      // directed table under both modes
      for (int m = 0; m < 2; m++) begin
         for (int r = 0; r < directed.size(); r++) begin
            p.centre_x = directed[r].cx; p.centre_y = directed[r].cy;
            p.centre_z = directed[r].cz; p.spin_angle = directed[r].ang;
            p.size_x = directed[r].sx; p.size_y = directed[r].sy;
            p.argb = directed[r].col;
            send_particle(p);
         end
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();
         write_csr(sbe_pkg::CSR_MODE, 16'd1);
      end

      // random phases, each with a fresh basis; extremes in the first two
      for (int ph = 0; ph < 6; ph++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();
         for (int r = 0; r < 6; r++) begin
            write_csr(3'(r), ph == 0 ? 16'h7fff : ph == 1 ? 16'h8000 : 16'($urandom()));
         end
         write_csr(sbe_pkg::CSR_MODE,
                   16'($urandom_range(0, 1)) | (ph[0] ? 16'hfffe : 16'h0));
         if (ph == 5) quiet_phase = 1'b1;
         for (int n = 0; n < RANDOM_PARTICLES / 6; n++) begin
            send_particle(rand_particle());
            // once, in the third phase, the sender holds off until every corner is back
            if (ph == 2 && n == 10) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (corner_queue.size() != 0) @(posedge clock);
            end
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();

      if (fail_count == 0) $display("sprite_billboard_expander regression: pass");
      else $display("sprite_billboard_expander regression: fail");
      $finish;
   end
endmodule
